FILE: design/warped_allpole_synth_filter_core_defines.svh
// Assertion macros for the warped all-pole synthesis filter core.
// Expects signals named clock and reset in the including scope.
`ifndef WARPED_ALLPOLE_SYNTH_FILTER_CORE_DEFINES_SVH
`define WARPED_ALLPOLE_SYNTH_FILTER_CORE_DEFINES_SVH

// Condition holds at every edge outside reset.
`define WASF_ASSERT_HOLDS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("wasf: invariant broken");

// Antecedent implies consequent in the same cycle.
`define WASF_ASSERT_IMPLIES(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("wasf: implication broken");

`endif

FILE: design/wasf_pkg.sv
// Shared types, constants and arithmetic helpers for the warped all-pole filter.
// No dependencies.
package wasf_pkg;

   localparam int MAX_POLES = 64;
   localparam int IDX_W     = 6;
   localparam int FRAC_BITS = 24;
   localparam int DATA_W    = 32;
   localparam int OPND_W    = 33;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int RND_W     = PROD_W - FRAC_BITS;
   localparam int ACC_W     = 50;
   localparam int DEN_W     = RND_W + 1;
   localparam int NUM_W     = 2 * FRAC_BITS + 1;
   localparam int WARP_W    = 25;
   localparam int PCNT_W    = 7;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_PREPARE = 2'd1;
   localparam logic [1:0] CMD_SAMPLE  = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_GAIN   = 1'b1;

   localparam logic signed [ACC_W-1:0] ONE_Q  = ACC_W'(1) <<< FRAC_BITS;
   localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic [NUM_W-1:0] GAIN_NUM = NUM_W'(1) << (2 * FRAC_BITS);

   typedef struct packed {
      logic [1:0]               cmd;
      logic [IDX_W-1:0]         coef_index;
      logic signed [DATA_W-1:0] data_value;
   } req_word_type;

   typedef struct packed {
      logic                     out_kind;
      logic signed [DATA_W-1:0] out_value;
      logic                     saturated;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]               op;
      logic                     emits;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] value;
   } op_type;

   typedef struct packed {
      logic       avail;
      logic [1:0] count;
   } queue_stat_type;

   typedef struct packed {
      logic pop;
      logic busy;
   } back_stat_type;

   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] val;
   } clip_type;

   function automatic clip_type clip32(input logic signed [ACC_W-1:0] v);
      clip_type r;
      if (v > ACC_W'(32'sh7FFFFFFF)) begin
         r.sat = 1'b1;
         r.val = 32'sh7FFFFFFF;
      end else if (v < -ACC_W'(64'sh80000000)) begin
         r.sat = 1'b1;
         r.val = 32'sh80000000;
      end else begin
         r.sat = 1'b0;
         r.val = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Round a full product to FRAC_BITS: add half, floor shift.
   function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p + HALF_Q;
      return signed'(s[PROD_W-1:FRAC_BITS]);
   endfunction

endpackage

FILE: design/wasf_front.sv
// Front end: accepts request words, classifies them, queues them for the engine.
// Depends on wasf_pkg.
module wasf_front import wasf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_word_type   req_word,
   input  logic           pop,
   output op_type         head,
   output queue_stat_type stat
);

   op_type     q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   op_type     cls;

   always_comb begin
      cls.op    = req_word.cmd;
      cls.emits = (req_word.cmd == CMD_PREPARE) || (req_word.cmd == CMD_SAMPLE);
      cls.idx   = req_word.coef_index;
      cls.value = req_word.data_value;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head       = q_mem_ff[rd_ptr_ff];
   assign stat.avail = (count_ff != 2'd0);
   assign stat.count = count_ff;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/wasf_div.sv
// Restoring divider, one quotient bit per cycle, for the frame gain.
// Depends on wasf_pkg.
module wasf_div import wasf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   sh;

   assign busy = busy_ff;
   assign quo  = quo_ff;

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sh      = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (sh >= {1'b0, den_ff}) begin
            rem_in = sh - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = sh;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

FILE: design/wasf_back.sv
// Back end: sequencer with one shared multiplier, coefficient and history stores.
// Depends on wasf_pkg and wasf_div.
module wasf_back import wasf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  op_type                   head,
   input  queue_stat_type           q_stat,
   input  logic [PCNT_W-1:0]        pole_count,
   input  logic signed [WARP_W-1:0] warp_factor,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output rsp_word_type             rsp_word,
   output back_stat_type            stat
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_SB    = 5'd1;
   localparam logic [4:0] ST_SC    = 5'd2;
   localparam logic [4:0] ST_SD    = 5'd3;
   localparam logic [4:0] ST_SE    = 5'd4;
   localparam logic [4:0] ST_SF    = 5'd5;
   localparam logic [4:0] ST_SG    = 5'd6;
   localparam logic [4:0] ST_SFIN  = 5'd7;
   localparam logic [4:0] ST_PB    = 5'd8;
   localparam logic [4:0] ST_PC    = 5'd9;
   localparam logic [4:0] ST_PD    = 5'd10;
   localparam logic [4:0] ST_PDEN  = 5'd11;
   localparam logic [4:0] ST_PDEN2 = 5'd12;
   localparam logic [4:0] ST_PFAC  = 5'd13;
   localparam logic [4:0] ST_PWAIT = 5'd14;
   localparam logic [4:0] ST_PFS   = 5'd15;
   localparam logic [4:0] ST_PFS2  = 5'd16;
   localparam logic [4:0] ST_OUT   = 5'd17;

   logic [4:0] state_ff, state_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic signed [DATA_W-1:0] keep_ff, keep_in, prev_ff, prev_in, hn_ff, hn_in;
   logic signed [DATA_W-1:0] cprev_ff, cprev_in, cur_ff, cur_in;
   logic signed [DATA_W-1:0] last_out_ff, last_out_in, fs_ff, fs_in;
   logic signed [DATA_W-1:0] fac_ff, fac_in, gain_ff, gain_in, res_ff, res_in;
   logic signed [RND_W-1:0]  t_ff, t_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DEN_W-1:0]  den_ff, den_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic sat_ff, sat_in, kind_ff, kind_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic signed [OPND_W-1:0] mul_a, mul_b, dq;
   logic signed [RND_W-1:0]  rp;
   logic [IDX_W-1:0] p_last;
   logic pop, rsp_free;

   // stores
   logic signed [DATA_W-1:0] coef_mem_ff [MAX_POLES];
   logic signed [DATA_W-1:0] hist_mem_ff [MAX_POLES];
   logic [MAX_POLES-1:0] coef_vld_ff, hist_vld_ff;
   logic signed [DATA_W-1:0] coef_rd_ff, hist_rd_ff, coef_q, hist_q;
   logic coef_rvld_ff, hist_rvld_ff;
   logic coef_we, hist_we, hist_clr;
   logic [IDX_W-1:0] coef_wa, coef_ra, hist_wa, hist_ra;
   logic signed [DATA_W-1:0] coef_wd, hist_wd;

   // divider
   logic div_start, div_busy;
   logic signed [DEN_W-1:0] den_c;
   logic [DEN_W-1:0] den_mag;
   logic [NUM_W-1:0] quo;

   clip_type ck;

   wasf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (GAIN_NUM),
      .den   (den_mag),
      .busy  (div_busy),
      .quo   (quo)
   );

   assign coef_q = coef_rvld_ff ? coef_rd_ff : '0;
   assign hist_q = hist_rvld_ff ? hist_rd_ff : '0;
   assign dq     = OPND_W'(warp_factor);
   assign rp     = round_q(prod_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (pole_count == '0) begin
         p_last = '0;
      end else if (pole_count > PCNT_W'(MAX_POLES)) begin
         p_last = IDX_W'(MAX_POLES - 1);
      end else begin
         p_last = IDX_W'(pole_count - PCNT_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;  n_in = n_ff;  keep_in = keep_ff;  prev_in = prev_ff;
      hn_in = hn_ff;  cprev_in = cprev_ff;  cur_in = cur_ff;
      last_out_in = last_out_ff;  fs_in = fs_ff;  fac_in = fac_ff;
      gain_in = gain_ff;  res_in = res_ff;  t_in = t_ff;  acc_in = acc_ff;
      den_in = den_ff;  sat_in = sat_ff;  kind_in = kind_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_word_in = rsp_word_ff;
      mul_a = '0;  mul_b = '0;  pop = 1'b0;
      coef_we = 1'b0;  coef_wa = '0;  coef_wd = '0;  coef_ra = '0;
      hist_we = 1'b0;  hist_wa = '0;  hist_wd = '0;  hist_ra = '0;  hist_clr = 1'b0;
      div_start = 1'b0;
      den_c = DEN_W'(ONE_Q) - DEN_W'(rp);
      den_mag = den_c[DEN_W-1] ? DEN_W'(-den_c) : DEN_W'(den_c);
      ck = clip32('0);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_stat.avail) begin
               pop = 1'b1;
               unique case (head.op)
                  CMD_LOAD: begin
                     coef_we = 1'b1;
                     coef_wa = head.idx;
                     coef_wd = head.value;
                  end
                  CMD_CLEAR: begin
                     hist_clr    = 1'b1;
                     last_out_in = '0;
                  end
                  CMD_PREPARE: begin
                     sat_in   = 1'b0;
                     coef_ra  = '0;
                     state_in = ST_PB;
                  end
                  CMD_SAMPLE: begin
                     sat_in   = 1'b0;
                     acc_in   = ACC_W'(head.value);
                     hist_ra  = p_last;
                     state_in = ST_SB;
                  end
                  default: ;
               endcase
            end
         end
         // sample: newest section from feedback
         ST_SB: begin
            keep_in  = hist_q;
            mul_a    = OPND_W'(fs_ff);
            mul_b    = OPND_W'(last_out_ff);
            state_in = ST_SC;
         end
         ST_SC: begin
            t_in     = rp;
            mul_a    = dq;
            mul_b    = OPND_W'(keep_ff);
            state_in = ST_SD;
         end
         ST_SD: begin
            ck      = clip32(ACC_W'(t_ff) - ACC_W'(rp));
            sat_in  = sat_ff | ck.sat;
            hn_in   = ck.val;
            hist_we = 1'b1;
            hist_wa = p_last;
            hist_wd = ck.val;
            n_in    = p_last;
            coef_ra = p_last;
            hist_ra = p_last - IDX_W'(1);
            state_in = ST_SE;
         end
         ST_SE: begin
            mul_a    = OPND_W'(coef_q);
            mul_b    = OPND_W'(hn_ff);
            prev_in  = hist_q;
            state_in = ST_SF;
         end
         ST_SF: begin
            acc_in = acc_ff + ACC_W'(rp);
            if (n_ff == '0) begin
               state_in = ST_SFIN;
            end else begin
               mul_a    = dq;
               mul_b    = OPND_W'(hn_ff) - OPND_W'(prev_ff);
               state_in = ST_SG;
            end
         end
         ST_SG: begin
            ck      = clip32(ACC_W'(rp) + ACC_W'(keep_ff));
            sat_in  = sat_ff | ck.sat;
            hn_in   = ck.val;
            keep_in = prev_ff;
            n_in    = n_ff - IDX_W'(1);
            hist_we = 1'b1;
            hist_wa = n_ff - IDX_W'(1);
            hist_wd = ck.val;
            coef_ra = n_ff - IDX_W'(1);
            hist_ra = n_ff - IDX_W'(2);
            state_in = ST_SE;
         end
         ST_SFIN: begin
            ck          = clip32(acc_ff);
            sat_in      = sat_ff | ck.sat;
            res_in      = ck.val;
            last_out_in = ck.val;
            kind_in     = KIND_SAMPLE;
            state_in    = ST_OUT;
         end
         // prepare: warp coefficients in place
         ST_PB: begin
            cprev_in = coef_q;
            if (p_last == '0) begin
               state_in = ST_PDEN;
            end else begin
               coef_ra  = IDX_W'(1);
               n_in     = IDX_W'(1);
               state_in = ST_PC;
            end
         end
         ST_PC: begin
            mul_a    = dq;
            mul_b    = OPND_W'(cprev_ff);
            cur_in   = coef_q;
            state_in = ST_PD;
         end
         ST_PD: begin
            ck       = clip32(ACC_W'(cur_ff) + ACC_W'(rp));
            sat_in   = sat_ff | ck.sat;
            coef_we  = 1'b1;
            coef_wa  = n_ff;
            coef_wd  = ck.val;
            cprev_in = ck.val;
            if (n_ff == p_last) begin
               state_in = ST_PDEN;
            end else begin
               coef_ra  = n_ff + IDX_W'(1);
               n_in     = n_ff + IDX_W'(1);
               state_in = ST_PC;
            end
         end
         ST_PDEN: begin
            mul_a    = dq;
            mul_b    = OPND_W'(cprev_ff);
            state_in = ST_PDEN2;
         end
         ST_PDEN2: begin
            den_in    = den_c;
            div_start = 1'b1;
            mul_a     = dq;
            mul_b     = dq;
            state_in  = ST_PFAC;
         end
         ST_PFAC: begin
            ck       = clip32(ONE_Q - ACC_W'(rp));
            sat_in   = sat_ff | ck.sat;
            fac_in   = ck.val;
            state_in = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (!div_busy) begin
               if (den_ff == '0) begin
                  gain_in = 32'sh7FFFFFFF;
                  sat_in  = 1'b1;
               end else begin
                  if (den_ff[DEN_W-1]) begin
                     ck = clip32(-ACC_W'(quo));
                  end else begin
                     ck = clip32(ACC_W'(quo));
                  end
                  sat_in  = sat_ff | ck.sat;
                  gain_in = ck.val;
               end
               state_in = ST_PFS;
            end
         end
         ST_PFS: begin
            mul_a    = OPND_W'(gain_ff);
            mul_b    = OPND_W'(fac_ff);
            state_in = ST_PFS2;
         end
         ST_PFS2: begin
            ck       = clip32(ACC_W'(rp));
            sat_in   = sat_ff | ck.sat;
            fs_in    = ck.val;
            res_in   = gain_ff;
            kind_in  = KIND_GAIN;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.out_kind  = kind_ff;
               rsp_word_in.out_value = res_ff;
               rsp_word_in.saturated = sat_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign stat.pop  = pop;
   assign stat.busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem_ff[coef_wa] <= coef_wd;
      end
      coef_rd_ff <= coef_mem_ff[coef_ra];
      if (hist_we) begin
         hist_mem_ff[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem_ff[hist_ra];
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;  keep_ff <= keep_in;  prev_ff <= prev_in;  hn_ff <= hn_in;
      cprev_ff <= cprev_in;  cur_ff <= cur_in;  fac_ff <= fac_in;
      gain_ff <= gain_in;  res_ff <= res_in;  t_ff <= t_in;  acc_ff <= acc_in;
      den_ff <= den_in;  sat_ff <= sat_in;  kind_ff <= kind_in;
      rsp_word_ff <= rsp_word_in;
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_out_ff  <= '0;
         fs_ff        <= '0;
         coef_vld_ff  <= '0;
         hist_vld_ff  <= '0;
         coef_rvld_ff <= 1'b0;
         hist_rvld_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_out_ff  <= last_out_in;
         fs_ff        <= fs_in;
         coef_rvld_ff <= coef_vld_ff[coef_ra];
         hist_rvld_ff <= hist_vld_ff[hist_ra];
         if (coef_we) begin
            coef_vld_ff[coef_wa] <= 1'b1;
         end
         if (hist_clr) begin
            hist_vld_ff <= '0;
         end else if (hist_we) begin
            hist_vld_ff[hist_wa] <= 1'b1;
         end
      end
   end

endmodule

FILE: design/warped_allpole_synth_filter_core.sv
// Top level of the warped all-pole synthesis filter: register port, front queue, engine.
// Depends on wasf_pkg, wasf_front, wasf_back and the assertion macro header.
//
//   channel | direction | handshake          | word
//   req_    | in        | req_valid/stall    | req_word_type (cmd, coef_index, data_value)
//   rsp_    | out       | rsp_valid/stall    | rsp_word_type (out_kind, out_value, saturated)
//   csr_    | in        | APB psel/penable   | pole_count at 0, warp_factor at 4
//
// Load and clear finish within the idle state of the engine. The single shared multiplier,
// the coefficient and history stores, each with one write and one read port, and the
// one-bit-per-cycle gain divider set the length of a sample and a prepare for P poles.
// Synchronous active-high reset empties the queue, clears the stores to zero by valid bits
// and restores the register defaults. The two-word queue keeps taking words while a result
// waits on a stalled output register.
`include "warped_allpole_synth_filter_core_defines.svh"

module warped_allpole_synth_filter_core import wasf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic REG_POLES = 1'b0;
   localparam logic REG_WARP  = 1'b1;

   logic [PCNT_W-1:0]        pole_count_ff, pole_count_in;
   logic signed [WARP_W-1:0] warp_ff, warp_in;
   logic                     csr_wr;
   op_type                   head;
   queue_stat_type           q_stat;
   back_stat_type            bk_stat;

   // register port: always ready, write on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      pole_count_in = pole_count_ff;
      warp_in       = warp_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_POLES: pole_count_in = csr_pwdata[PCNT_W-1:0];
            REG_WARP:  warp_in       = signed'(csr_pwdata[WARP_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_POLES: csr_prdata = 32'(pole_count_ff);
         REG_WARP:  csr_prdata = 32'(unsigned'(warp_ff));
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_count_ff <= PCNT_W'(24);
         warp_ff       <= '0;
      end else begin
         pole_count_ff <= pole_count_in;
         warp_ff       <= warp_in;
      end
   end

   // front: take and classify words, hold up to two
   wasf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .pop       (bk_stat.pop),
      .head      (head),
      .stat      (q_stat)
   );

   // back: run each command to completion
   wasf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_stat      (q_stat),
      .pole_count  (pole_count_ff),
      .warp_factor (warp_ff),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .stat        (bk_stat)
   );

   `WASF_ASSERT_HOLDS(a_queue_bound, q_stat.count != 2'd3)
   `WASF_ASSERT_IMPLIES(a_pop_has_word, bk_stat.pop, q_stat.avail && !bk_stat.busy)
   `WASF_ASSERT_IMPLIES(a_rsp_from_engine, $rose(rsp_valid), $past(bk_stat.busy))

endmodule

FILE: dv/wasf_scoreboard.sv
// Scoreboard for the warped all-pole synthesis filter core: watches the word channels
// and the register port, predicts each result and compares it. Depends on wasf_pkg.
`timescale 1ns / 100ps

module wasf_scoreboard import wasf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           errors,
   output int           pending
);

   localparam logic [2:0] ADDR_POLES = 3'd0;
   localparam logic [2:0] ADDR_WARP  = 3'd4;

   logic [6:0]         poles_reg;
   logic signed [24:0] warp_reg;
   int                 hist_mem [MAX_POLES];
   int                 coef_mem [MAX_POLES];
   int                 fb_last;
   int                 fb_scale;
   rsp_word_type       awaited_words [$];

   initial errors = 0;
   assign pending = awaited_words.size();

   function automatic longint qmul(input longint a, input longint b);
      longint p;
      p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
   endfunction

   function automatic int sat32(input longint v, inout bit flag);
      if (v > 64'sh7FFFFFFF) begin
         flag = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sh80000000) begin
         flag = 1'b1;
         return 32'sh80000000;
      end
      return int'(v);
   endfunction

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   // Work out the filter's answer to one accepted word; queue it if there is one.
   task automatic filter_word(input req_word_type w);
      longint       d, one, den, gain, fac, keep, prev, acc;
      int           np;
      bit           sat;
      rsp_word_type r;
      d   = longint'(warp_reg);
      one = 64'sd1 <<< FRAC_BITS;
      np  = (poles_reg == 0) ? 1 : ((poles_reg > MAX_POLES) ? MAX_POLES : int'(poles_reg));
      sat = 1'b0;
      case (w.cmd)
         CMD_LOAD: coef_mem[w.coef_index] = w.data_value;
         CMD_CLEAR: begin
            foreach (hist_mem[i]) hist_mem[i] = 0;
            fb_last = 0;
         end
         CMD_PREPARE: begin
            for (int n = 1; n < np; n++)
               coef_mem[n] = sat32(longint'(coef_mem[n]) + qmul(d, coef_mem[n-1]), sat);
            den = one - qmul(d, coef_mem[np-1]);
            if (den == 0) begin
               gain = 64'sh7FFFFFFF;
               sat  = 1'b1;
            end else begin
               gain = sat32((64'sd1 <<< (2 * FRAC_BITS)) / den, sat);
            end
            fac      = sat32(one - qmul(d, d), sat);
            fb_scale = sat32(qmul(gain, fac), sat);
            r.out_kind  = KIND_GAIN;
            r.out_value = int'(gain);
            r.saturated = sat;
            awaited_words.push_back(r);
         end
         default: begin
            keep = hist_mem[np-1];
            acc  = longint'(w.data_value);
            hist_mem[np-1] = sat32(qmul(fb_scale, fb_last) - qmul(d, hist_mem[np-1]), sat);
            for (int n = np - 1; n > 0; n--) begin
               prev = hist_mem[n-1];
               hist_mem[n-1] = sat32(qmul(d, longint'(hist_mem[n]) - prev) + keep, sat);
               keep = prev;
            end
            for (int n = 0; n < np; n++) acc += qmul(coef_mem[n], hist_mem[n]);
            fb_last = sat32(acc, sat);
            r.out_kind  = KIND_SAMPLE;
            r.out_value = fb_last;
            r.saturated = sat;
            awaited_words.push_back(r);
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         poles_reg = 7'd24;
         warp_reg  = '0;
         foreach (hist_mem[i]) hist_mem[i] = 0;
         foreach (coef_mem[i]) coef_mem[i] = 0;
         fb_last  = 0;
         fb_scale = 0;
         awaited_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_POLES) poles_reg = csr_pwdata[6:0];
            else if (csr_paddr == ADDR_WARP) warp_reg = csr_pwdata[24:0];
         end
         if (req_valid && !req_stall) filter_word(req_word);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               report($sformatf("unexpected result %h", rsp_word));
            end else begin
               e = awaited_words.pop_front();
               if (rsp_word.out_kind !== e.out_kind)
                  report($sformatf("out_kind %b, want %b", rsp_word.out_kind, e.out_kind));
               if (rsp_word.out_value !== e.out_value)
                  report($sformatf("out_value %h, want %h", rsp_word.out_value, e.out_value));
               if (rsp_word.saturated !== e.saturated)
                  report($sformatf("saturated %b, want %b", rsp_word.saturated, e.saturated));
            end
         end
      end
   end

endmodule

FILE: dv/testbench.sv
// Top of the filter core testbench: clock, reset, stimulus and verdict.
// Depends on wasf_pkg, the filter core and wasf_scoreboard.
`timescale 1ns / 100ps

module testbench;
   import wasf_pkg::*;

   localparam logic [2:0] ADDR_POLES = 3'd0;
   localparam logic [2:0] ADDR_WARP  = 3'd4;
   localparam int SETTLE_CYCLES = 260;      // longest prepare at 64 poles plus queued words
   localparam int CYCLE_LIMIT   = 4000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           errors;
   int           pending;

   // Idling controls: busy mode suppresses all gaps; hold_go asks for one long receiver stall.
   bit           busy_mode = 1'b0;
   logic         hold_go = 1'b0;
   int           hold_cnt = 0;
   int           rsp_wait = 0;
   int           cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   warped_allpole_synth_filter_core uut (.*);

   wasf_scoreboard scoreboard (.*);

   function automatic int draw_gap();
      return busy_mode ? 0 : int'($urandom_range(0, 19));
   endfunction

   // Long receiver hold, counted here so the sender keeps pushing into a full queue.
   always @(posedge clock) begin
      if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
      else if (hold_go) hold_cnt <= 400;
   end

   // Receiver: draw a fresh stall length after each accepted result word.
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else if (hold_cnt > 1 || (hold_go && hold_cnt == 0)) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         n = draw_gap();
         rsp_wait  <= n;
         rsp_stall <= (n != 0);
      end else if (rsp_wait > 1) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_wait  <= 0;
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one word after a drawn gap and hold it until accepted; valid stays up if no gap.
   task automatic send_word(input logic [1:0] cmd, input logic [5:0] idx, input int value);
      int  gap;
      bit  stalled;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_word.cmd        <= cmd;
      req_word.coef_index <= idx;
      req_word.data_value <= value;
      forever begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
         if (!stalled) break;
      end
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every awaited result, then let the engine run dry.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_filter(input logic [6:0] poles, input int warp);
      drain();
      csr_write(ADDR_POLES, 32'(poles));
      csr_write(ADDR_WARP, 32'(warp));
   endtask

   // Excitation or coefficient: mostly modest Q8.24 values, sometimes any 32-bit word.
   function automatic int pick_value(input int shift);
      if ($urandom_range(0, 9) == 0) return int'($urandom());
      return int'($urandom()) >>> shift;
   endfunction

   function automatic int pick_warp();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 16777215;
         2: return -16777215;
         default: return int'($urandom_range(0, 30000000)) - 15000000;
      endcase
   endfunction

   function automatic logic [6:0] pick_poles();
      case ($urandom_range(0, 9))
         0: return 7'd64;
         1: return 7'd0;
         2: return 7'd127;
         default: return 7'($urandom_range(1, 12));
      endcase
   endfunction

   // One frame: load coefficients, prepare, then samples with the odd clear and stray word.
   task automatic run_frame(input int np, inout int sent);
      int shift, nsamp;
      shift = $urandom_range(4, 10);
      for (int i = 0; i < np; i++) begin
         send_word(CMD_LOAD, 6'(i), pick_value(shift));
         sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
         send_word(CMD_PREPARE, 6'($urandom()), int'($urandom()));
         sent++;
      end
      nsamp = $urandom_range(4, 30);
      for (int i = 0; i < nsamp; i++) begin
         case ($urandom_range(0, 19))
            0: send_word(CMD_CLEAR, 6'($urandom()), int'($urandom()));
            1: send_word(CMD_LOAD, 6'($urandom()), int'($urandom()));
            2: send_word(CMD_PREPARE, 6'($urandom()), int'($urandom()));
            default: send_word(CMD_SAMPLE, 6'($urandom()), pick_value(4));
         endcase
         sent++;
      end
   endtask

   initial begin
      int sent, np;
      logic [6:0] poles;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: sample before any prepare, defaults, extremes of the data field.
      send_word(CMD_SAMPLE, 6'd0, 32'sh7FFFFFFF);
      send_word(CMD_LOAD, 6'd0, 32'sh01000000);
      send_word(CMD_LOAD, 6'd63, 32'sh80000000);
      send_word(CMD_LOAD, 6'd23, 32'sh7FFFFFFF);
      send_word(CMD_PREPARE, 6'd0, 0);
      send_word(CMD_SAMPLE, 6'd63, 32'sh80000000);
      send_word(CMD_SAMPLE, 6'd0, 32'sh00800000);
      send_word(CMD_CLEAR, 6'd0, 0);
      send_word(CMD_SAMPLE, 6'd0, -1);

      // Zero gain divisor: one pole, d = 0.5, c = 2.0.
      set_filter(7'd1, 32'sh00800000);
      send_word(CMD_LOAD, 6'd0, 32'sh02000000);
      send_word(CMD_PREPARE, 6'd0, 0);
      send_word(CMD_SAMPLE, 6'd0, 32'sh01000000);

      // Warp at its extremes, all 64 poles, then out-of-range pole counts.
      set_filter(7'd64, -16777215);
      send_word(CMD_LOAD, 6'd5, 32'sh7FFFFFFF);
      send_word(CMD_PREPARE, 6'd0, 0);
      send_word(CMD_SAMPLE, 6'd0, 32'sh7FFFFFFF);
      set_filter(7'd0, 16777215);
      send_word(CMD_PREPARE, 6'd0, 0);
      send_word(CMD_SAMPLE, 6'd0, 32'sh40000000);
      set_filter(7'd127, 16777215);
      send_word(CMD_PREPARE, 6'd0, 0);
      send_word(CMD_SAMPLE, 6'd0, -32'sh40000000);

      // Random frames under a spread of settings.
      sent = 0;
      while (sent < 1750) begin
         poles = pick_poles();
         set_filter(poles, pick_warp());
         np = (poles == 0) ? 1 : ((poles > 64) ? 64 : int'(poles));
         busy_mode = ($urandom_range(0, 4) == 0);
         if (sent > 600 && sent < 700) begin
            // Fill the queue behind a long receiver hold.
            busy_mode = 1'b1;
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         run_frame(np, sent);
         busy_mode = 1'b0;
      end

      drain();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
